// File: rtl/glp_pkg.sv
// Shared types and constants for the premultiplied gamma lookup block.
package glp_pkg;

  localparam int ChW          = 8;
  localparam int AlphaW       = ChW + 1;
  localparam int TableDepth   = 256;
  localparam int TableAw      = $clog2(TableDepth);
  localparam int NumLanes     = 3;
  localparam int DivStages    = 4;
  localparam int BitsPerStage = ChW / DivStages;
  localparam int FifoDepth    = 16;
  localparam int FifoAw       = $clog2(FifoDepth);
  localparam int CntW         = FifoAw + 1;

  localparam logic [ChW-1:0]    SatVal     = 8'd255;
  localparam logic [AlphaW-1:0] AlphaUnity = 9'd256;

  // Beat control carried alongside the channel data in each lane
  typedef struct packed {
    logic               pix;
    logic               wr;
    logic [TableAw-1:0] idx;
    logic [ChW-1:0]     val;
  } glp_ctl_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic           invalid;
  } glp_res_t;

endpackage

// File: rtl/glp_lane.sv
// One colour lane: pipelined unpremultiply divider, gamma table copy and remultiply.
module glp_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  glp_pkg::glp_ctl_t           ctl_i,
  input  logic [glp_pkg::ChW-1:0]     ch_i,
  input  logic [glp_pkg::AlphaW-1:0]  alpha_i,
  output logic                        pix_o,
  output logic [glp_pkg::ChW-1:0]     val_o,
  output logic                        bad_o
);
  import glp_pkg::*;

  // Two restoring division steps; remainder stays below alpha
  function automatic logic [2*ChW-1:0] div_step(input logic [ChW-1:0]    rem,
                                                 input logic [ChW-1:0]    quo,
                                                 input logic [AlphaW-1:0] alpha);
    logic [AlphaW-1:0] t;
    logic [ChW-1:0]    r;
    logic [ChW-1:0]    q;
    r = rem;
    q = quo;
    for (int i = 0; i < BitsPerStage; i++) begin
      t = {r, 1'b0};
      if (t >= alpha) begin
        t = t - alpha;
        q = {q[ChW-2:0], 1'b1};
      end else begin
        q = {q[ChW-2:0], 1'b0};
      end
      r = t[ChW-1:0];
    end
    return {r, q};
  endfunction

  glp_ctl_t          ctl_q   [DivStages];
  logic [ChW-1:0]    rem_d   [DivStages];
  logic [ChW-1:0]    quo_d   [DivStages];
  logic [ChW-1:0]    rem_q   [DivStages];
  logic [ChW-1:0]    quo_q   [DivStages];
  logic [AlphaW-1:0] alpha_q [DivStages];
  logic              bad_q   [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    glp_ctl_t          ctl_in;
    logic [ChW-1:0]    rem_in;
    logic [ChW-1:0]    quo_in;
    logic [AlphaW-1:0] alpha_in;
    logic              bad_in;

    if (k == 0) begin : g_first
      // A channel at or above alpha would give a quotient past full scale
      assign ctl_in   = ctl_i;
      assign alpha_in = alpha_i;
      assign bad_in   = ({1'b0, ch_i} >= alpha_i);
      assign rem_in   = bad_in ? '0 : ch_i;
      assign quo_in   = '0;
    end else begin : g_next
      assign ctl_in   = ctl_q[k-1];
      assign alpha_in = alpha_q[k-1];
      assign bad_in   = bad_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
    end

    assign {rem_d[k], quo_d[k]} = div_step(rem_in, quo_in, alpha_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]   <= rem_d[k];
      quo_q[k]   <= quo_d[k];
      alpha_q[k] <= alpha_in;
      bad_q[k]   <= bad_in;
    end
  end

  localparam int Last = DivStages - 1;

  logic [ChW-1:0]     lut_mem [TableDepth];
  logic [TableAw-1:0] rd_addr;
  logic [ChW-1:0]     rd_q;
  logic               pix_m_q;
  logic [AlphaW-1:0]  alpha_m_q;
  logic               bad_m_q;
  logic [ChW+AlphaW-1:0] prod;

  assign rd_addr = bad_q[Last] ? TableAw'(SatVal) : TableAw'(quo_q[Last]);

  // Table beats and pixel beats occupy distinct slots, so a write lands before any later read
  always_ff @(posedge clk_i) begin
    if (ctl_q[Last].wr) begin
      lut_mem[ctl_q[Last].idx] <= ctl_q[Last].val;
    end
    rd_q <= lut_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_m_q <= 1'b0;
    end else begin
      pix_m_q <= ctl_q[Last].pix;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_m_q <= alpha_q[Last];
    bad_m_q   <= bad_q[Last];
  end

  // Opaque pixels carry alpha of 256, so the remultiply leaves them untouched
  assign prod  = (ChW+AlphaW)'(rd_q) * (ChW+AlphaW)'(alpha_m_q);
  assign val_o = prod[2*ChW-1:ChW];
  assign pix_o = pix_m_q;
  assign bad_o = bad_m_q;

endmodule

// File: rtl/glp_fifo.sv
// Result queue that parts the pipeline from the output handshake.
module glp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  glp_pkg::glp_res_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output glp_pkg::glp_res_t data_o
);
  import glp_pkg::*;

  glp_res_t          mem [FifoDepth];
  logic [FifoAw:0]   wr_ptr_q;
  logic [FifoAw:0]   rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q[FifoAw-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign data_o  = mem[rd_ptr_q[FifoAw-1:0]];

endmodule

// File: rtl/gamma_lut_premultiplied.sv
// Top level: gamma lookup on premultiplied RGB pixels, one lane per colour.
//
//  channel | direction | handshake                  | payload
//  in      | sink      | in_valid_i / in_stall_o    | mode, rgb, alpha complement, table entry
//  out     | source    | out_valid_o / out_stall_i  | corrected rgb, invalid flag
//
//  One beat per clock while in_stall_o is low, pixel or table write alike; a pixel
//  result is offered once its beat has passed the input register, four divider
//  stages of two quotient bits each, the table read and the remultiply into the queue.
//  Reset clears the pipeline and the result queue; the gamma tables are not cleared.
//  in_stall_o rises only when 16 pixel results are outstanding, so with out_stall_i
//  low the block never stalls.
module gamma_lut_premultiplied (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_complement_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] entry_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       invalid_color_o
);
  import glp_pkg::*;

  logic              in_take;
  logic              out_take;
  glp_ctl_t          ctl_s0_q;
  logic [ChW-1:0]    ch_s0_q [NumLanes];
  logic [AlphaW-1:0] alpha_s0_q;
  logic [CntW-1:0]   cnt_d;
  logic [CntW-1:0]   cnt_q;

  logic [NumLanes-1:0] lane_pix;
  logic [NumLanes-1:0] lane_bad;
  logic [ChW-1:0]      lane_val [NumLanes];

  glp_res_t merged;
  glp_res_t head;

  assign in_take  = in_valid_i & ~in_stall_o;
  assign out_take = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s0_q <= '0;
    end else begin
      ctl_s0_q.pix <= in_take & ~mode_i;
      ctl_s0_q.wr  <= in_take & mode_i;
      ctl_s0_q.idx <= TableAw'(entry_index_i);
      ctl_s0_q.val <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_s0_q[0] <= red_in_i;
    ch_s0_q[1] <= green_in_i;
    ch_s0_q[2] <= blue_in_i;
    alpha_s0_q <= AlphaUnity - AlphaW'(alpha_complement_i);
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    glp_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_s0_q),
      .ch_i    (ch_s0_q[l]),
      .alpha_i (alpha_s0_q),
      .pix_o   (lane_pix[l]),
      .val_o   (lane_val[l]),
      .bad_o   (lane_bad[l])
    );
  end

  // Merge the lanes into one result beat
  assign merged.red     = lane_val[0];
  assign merged.green   = lane_val[1];
  assign merged.blue    = lane_val[2];
  assign merged.invalid = |lane_bad;

  glp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (lane_pix[0]),
    .data_i  (merged),
    .pop_i   (out_take),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  // Count pixels in flight or queued; hold the input once the queue could overflow
  always_comb begin
    cnt_d = cnt_q;
    if (in_take && !mode_i) begin
      cnt_d = cnt_d + 1'b1;
    end
    if (out_take) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign in_stall_o      = (cnt_q == CntW'(FifoDepth));
  assign red_out_o       = head.red;
  assign green_out_o     = head.green;
  assign blue_out_o      = head.blue;
  assign invalid_color_o = head.invalid;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("outstanding pixel count past queue depth");

  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !out_valid_o)
    else $error("result offered with no pixel outstanding");

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&lane_pix) == (|lane_pix))
    else $error("colour lanes out of step");

  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> !ctl_s0_q.pix && !ctl_s0_q.wr)
    else $error("beat entered the pipeline while stalled");

endmodule

// File: bench/gamma_result_checker.sv
// Channel monitor that predicts each corrected pixel and compares it with the block's output.
`timescale 1ns / 1ps
module gamma_result_checker #(
  parameter logic ModeWrite = 1'b1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    mode_i,
  input  logic [glp_pkg::ChW-1:0] red_in_i,
  input  logic [glp_pkg::ChW-1:0] green_in_i,
  input  logic [glp_pkg::ChW-1:0] blue_in_i,
  input  logic [glp_pkg::ChW-1:0] alpha_complement_i,
  input  logic [glp_pkg::ChW-1:0] entry_index_i,
  input  logic [glp_pkg::ChW-1:0] entry_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [glp_pkg::ChW-1:0] red_out_i,
  input  logic [glp_pkg::ChW-1:0] green_out_i,
  input  logic [glp_pkg::ChW-1:0] blue_out_i,
  input  logic                    invalid_color_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  import glp_pkg::*;

  logic [ChW-1:0] gamma_shadow [TableDepth];
  glp_res_t       corrected_q [$];
  glp_res_t       want;
  glp_res_t       got;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Unpremultiply, saturate, look up and remultiply one channel; top bit flags saturation
  function automatic logic [ChW:0] remap_channel(input logic [ChW-1:0]    ch,
                                                 input logic [AlphaW-1:0] alpha);
    logic [2*ChW-1:0] unpre;
    logic [ChW-1:0]   idx;
    logic [2*ChW:0]   prod;
    logic             over;
    unpre = {ch, {ChW{1'b0}}} / (2*ChW)'(alpha);
    over  = unpre > (2*ChW)'(SatVal);
    idx   = over ? SatVal : unpre[ChW-1:0];
    prod  = (2*ChW+1)'(gamma_shadow[idx]) * (2*ChW+1)'(alpha);
    return {over, prod[2*ChW-1:ChW]};
  endfunction

  // An opaque pixel behaves as alpha of unity: direct lookup, never saturated
  function automatic glp_res_t predict_pixel(input logic [ChW-1:0] r, input logic [ChW-1:0] g,
                                             input logic [ChW-1:0] b,
                                             input logic [ChW-1:0] comp);
    logic [AlphaW-1:0] alpha;
    logic [ChW:0]      lr;
    logic [ChW:0]      lg;
    logic [ChW:0]      lb;
    glp_res_t          res;
    alpha       = AlphaUnity - AlphaW'(comp);
    lr          = remap_channel(r, alpha);
    lg          = remap_channel(g, alpha);
    lb          = remap_channel(b, alpha);
    res.red     = lr[ChW-1:0];
    res.green   = lg[ChW-1:0];
    res.blue    = lb[ChW-1:0];
    res.invalid = lr[ChW] | lg[ChW] | lb[ChW];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == ModeWrite) begin
          gamma_shadow[entry_index_i] = entry_value_i;
        end else begin
          corrected_q.push_back(predict_pixel(red_in_i, green_in_i, blue_in_i,
                                              alpha_complement_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got.red     = red_out_i;
        got.green   = green_out_i;
        got.blue    = blue_out_i;
        got.invalid = invalid_color_i;
        if (corrected_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected pixel beat r=%0d g=%0d b=%0d inv=%0b", $realtime,
                     got.red, got.green, got.blue, got.invalid);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = corrected_q.pop_front();
          if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue ||
              want.invalid !== got.invalid) begin
            if (fail_count_o < 10)
              $display("%0t: pixel exp r=%0d g=%0d b=%0d inv=%0b got r=%0d g=%0d b=%0d inv=%0b",
                       $realtime, want.red, want.green, want.blue, want.invalid,
                       got.red, got.green, got.blue, got.invalid);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_o = corrected_q.size();
    end
  end

endmodule

// File: bench/gamma_lut_premultiplied_tb.sv
// Stimulus and verdict for the premultiplied gamma lookup block.
`timescale 1ns / 1ps
module gamma_lut_premultiplied_tb;
  import glp_pkg::*;

  localparam logic ModePixel   = 1'b0;
  localparam logic ModeWrite   = 1'b1;
  localparam int   MaxGap      = 16;
  localparam int   HoldCycles  = 300;
  localparam int   HoldAfter   = 300;
  localparam int   IdleLimit   = 2000;
  localparam int   DrainCycles = 20;
  localparam int   RandomItems = 1380;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           mode = ModePixel;
  logic [ChW-1:0] red_in = '0;
  logic [ChW-1:0] green_in = '0;
  logic [ChW-1:0] blue_in = '0;
  logic [ChW-1:0] alpha_comp = '0;
  logic [ChW-1:0] entry_index = '0;
  logic [ChW-1:0] entry_value = '0;
  logic           out_valid;
  logic           out_stall = 1'b1;
  logic [ChW-1:0] red_out;
  logic [ChW-1:0] green_out;
  logic [ChW-1:0] blue_out;
  logic           invalid_color;
  int             fail_count;
  int             pending;
  int             beats_sent = 0;
  int             beats_taken = 0;
  int             idle_cycles = 0;
  bit             hold_active = 1'b0;

  always #5 clk_i = ~clk_i;

  gamma_lut_premultiplied uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .mode_i             (mode),
    .red_in_i           (red_in),
    .green_in_i         (green_in),
    .blue_in_i          (blue_in),
    .alpha_complement_i (alpha_comp),
    .entry_index_i      (entry_index),
    .entry_value_i      (entry_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .red_out_o          (red_out),
    .green_out_o        (green_out),
    .blue_out_o         (blue_out),
    .invalid_color_o    (invalid_color)
  );

  gamma_result_checker #(.ModeWrite(ModeWrite)) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .mode_i             (mode),
    .red_in_i           (red_in),
    .green_in_i         (green_in),
    .blue_in_i          (blue_in),
    .alpha_complement_i (alpha_comp),
    .entry_index_i      (entry_index),
    .entry_value_i      (entry_value),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .red_out_i          (red_out),
    .green_out_i        (green_out),
    .blue_out_i         (blue_out),
    .invalid_color_i    (invalid_color),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Every fourth stretch of a hundred beats runs without idling
  function automatic int draw_gap(input int count);
    if (hold_active || (count / 100) % 4 == 3) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  task automatic send_beat(input logic m, input logic [ChW-1:0] r, input logic [ChW-1:0] g,
                           input logic [ChW-1:0] b, input logic [ChW-1:0] comp,
                           input logic [ChW-1:0] idx, input logic [ChW-1:0] val);
    int gap;
    gap = draw_gap(beats_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    red_in      <= r;
    green_in    <= g;
    blue_in     <= b;
    alpha_comp  <= comp;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [ChW-1:0] r, input logic [ChW-1:0] g,
                            input logic [ChW-1:0] b, input logic [ChW-1:0] comp);
    send_beat(ModePixel, r, g, b, comp, ChW'($urandom_range(0, 255)),
              ChW'($urandom_range(0, 255)));
  endtask

  task automatic send_entry(input logic [ChW-1:0] idx, input logic [ChW-1:0] val);
    send_beat(ModeWrite, ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
              ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)), idx, val);
  endtask

  // Result side: random stall per beat, one long hold-off to back the block up
  initial begin
    int k;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && beats_taken >= HoldAfter) begin
        held        = 1'b1;
        hold_active = 1'b1;
        out_stall  <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_active = 1'b0;
      end else begin
        k = draw_gap(beats_taken);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(negedge clk_i);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      beats_taken++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int             sel;
    logic [ChW-1:0] comp;
    logic [ChW-1:0] lim;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole table first so no pixel can read an unwritten entry
    for (int i = 0; i < TableDepth; i++) send_entry(ChW'(i), ChW'($urandom_range(0, 255)));

    // Opaque extremes
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255, 8'd0);
    // Smallest alpha: only zero survives, anything else saturates
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    // Largest non-opaque alpha, either side of the saturation boundary
    send_pixel(8'd254, 8'd254, 8'd254, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd254, 8'd1);
    // Half alpha: boundary held, then each channel saturating on its own
    send_pixel(8'd127, 8'd127, 8'd127, 8'd128);
    send_pixel(8'd128, 8'd0, 8'd64, 8'd128);
    send_pixel(8'd0, 8'd128, 8'd0, 8'd128);
    send_pixel(8'd0, 8'd0, 8'd128, 8'd128);
    send_pixel(8'd55, 8'd56, 8'd20, 8'd200);
    // Rewrite entries and read them straight back
    send_entry(8'd255, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    send_entry(8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_entry(8'd128, 8'd255);
    send_pixel(8'd64, 8'd64, 8'd64, 8'd128);
    send_entry(8'd255, 8'd255);
    send_pixel(8'd255, 8'd200, 8'd100, 8'd1);

    for (int n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        send_entry(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)));
      end else if (sel < 25) begin
        send_pixel(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
                   ChW'($urandom_range(0, 255)), 8'd0);
      end else if (sel < 85) begin
        // Well-formed premultiplied colour: every channel below alpha
        comp = ChW'($urandom_range(1, 255));
        lim  = 8'd255 - comp;
        send_pixel(ChW'($urandom_range(0, lim)), ChW'($urandom_range(0, lim)),
                   ChW'($urandom_range(0, lim)), comp);
      end else begin
        send_pixel(ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)),
                   ChW'($urandom_range(0, 255)), ChW'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
